FILE: rtl/dlk_pkg.sv
// Shared types and constants of the display link keepalive receiver.
// Item and result records, status codes, request codes and frame byte values.
`timescale 1ns / 1ps

package dlk_pkg;

  typedef enum logic [2:0] {
    REQ_FRAME   = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_POP     = 3'd2,
    REQ_ARM     = 3'd3,
    REQ_RELEASE = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WAIT    = 3'd1,
    ST_PARTIAL = 3'd2,
    ST_DONE    = 3'd3,
    ST_ERROR   = 3'd4
  } slot_st_t;

  // Configuration register indexes
  localparam logic [2:0] REG_SYNC_TX_ID   = 3'd0;
  localparam logic [2:0] REG_SYNC_RX_ID   = 3'd1;
  localparam logic [2:0] REG_REPLY_MASK   = 3'd2;
  localparam logic [2:0] REG_KEYPRESS_ID  = 3'd3;
  localparam logic [2:0] REG_TEXT_FUNC_ID = 3'd4;
  localparam logic [2:0] REG_CTRL_FUNC_ID = 3'd5;
  localparam logic [2:0] REG_PING_LIMIT   = 3'd6;
  localparam logic [2:0] REG_FILLER_BYTE  = 3'd7;

  // Link flag bits
  localparam logic [2:0] LF_FAILED = 3'b001;
  localparam logic [2:0] LF_START  = 3'b010;
  localparam logic [2:0] LF_ALIVE  = 3'b100;

  localparam logic [6:0] PING_LIMIT_RST = 7'd10;
  localparam logic [7:0] FILLER_RST     = 8'h81;

  // Frame byte values
  localparam logic [7:0] B_SYNC_REQ0  = 8'h61;
  localparam logic [7:0] B_SYNC_REQ1  = 8'h11;
  localparam logic [7:0] B_ALIVE      = 8'h69;
  localparam logic [7:0] B_ACK        = 8'h74;
  localparam logic [7:0] B_PART0      = 8'h30;
  localparam logic [7:0] B_KEY_HDR    = 8'h03;
  localparam logic [7:0] B_KEY_PRESS  = 8'h89;
  localparam logic [7:0] B_PING       = 8'h79;
  localparam logic [7:0] B_SYNC_OUT   = 8'h7A;
  localparam logic [7:0] B_ANSWER0    = 8'h70;
  localparam logic [7:0] B_ANSWER1    = 8'h1A;
  localparam logic [7:0] B_PAD_FIXED  = 8'h81;
  localparam logic [7:0] B_ONE        = 8'h01;
  localparam logic [7:0] B_ZERO       = 8'h00;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] frame_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic        slot;
  } item_t;

  typedef struct packed {
    logic [10:0] sync_tx_id;
    logic [10:0] sync_rx_id;
    logic [10:0] reply_flag_mask;
    logic [10:0] keypress_id;
    logic [10:0] text_func_id;
    logic [10:0] ctrl_func_id;
    logic [6:0]  ping_limit;
    logic [7:0]  filler_byte;
  } cfg_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_data;
    logic        last;
    logic        key_valid;
    logic [15:0] key_code;
    logic [2:0]  link_status;
    logic [2:0]  text_slot_status;
    logic [2:0]  ctrl_slot_status;
  } res_t;

endpackage

FILE: rtl/dlk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module dlk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dlk_engine.sv
// Per-item logic and link, slot and key queue state of the receiver.
// Uses dlk_pkg and one dlk_ram for the key queue.
`timescale 1ns / 1ps

module dlk_engine #(
  parameter int KEY_QUEUE_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  dlk_pkg::item_t item,
  input  dlk_pkg::cfg_t  cfg,
  output dlk_pkg::res_t  res0,
  output dlk_pkg::res_t  res1,
  output logic          two_res
);
  import dlk_pkg::*;

  localparam int PW = $clog2(KEY_QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(KEY_QUEUE_DEPTH - 1);

  logic [2:0]    lf_r, lf_nxt;
  logic [6:0]    cd_r, cd_nxt;
  slot_st_t      ss_r [2];
  slot_st_t      ss_nxt [2];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc, raddr;
  logic          push, do_tick, kv, slot_hit, slot_sel;
  logic [15:0]   kc, ram_rdata, byp_data_r;
  logic          byp_r;
  logic [10:0]   base_id;
  logic [6:0]    cd_dec;
  logic          f0_v, f1_v;
  logic [10:0]   f0_id;
  logic [63:0]   f0_data, f1_data;
  logic [7:0]    fb;

  assign fb     = cfg.filler_byte;
  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
  assign base_id = item.frame_id & ~cfg.reply_flag_mask;
  assign kc = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    lf_nxt    = lf_r;
    cd_nxt    = cd_r;
    ss_nxt[0] = ss_r[0];
    ss_nxt[1] = ss_r[1];
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    push      = 1'b0;
    do_tick   = 1'b0;
    kv        = 1'b0;
    slot_hit  = 1'b0;
    slot_sel  = 1'b0;
    cd_dec    = '0;
    f0_v      = 1'b0;
    f0_id     = '0;
    f0_data   = '0;
    f1_v      = 1'b0;
    f1_data   = '0;
    case (item.req_type)
      REQ_FRAME: begin
        if (item.frame_id == cfg.sync_rx_id) begin
          if (item.byte0 == B_SYNC_REQ0 && item.byte1 == B_SYNC_REQ1) begin
            f0_v    = 1'b1;
            f0_id   = cfg.sync_tx_id;
            f0_data = {B_ANSWER0, B_ANSWER1, B_SYNC_REQ1, B_ZERO,
                       B_ZERO, B_ZERO, B_ZERO, B_ONE};
            lf_nxt  = lf_r & ~LF_FAILED;
            if (item.byte2 == B_ONE) begin
              lf_nxt = lf_nxt | LF_START;
            end
          end else if (item.byte0 == B_ALIVE) begin
            lf_nxt  = lf_r | LF_ALIVE;
            do_tick = 1'b1;
          end
        end else if ((item.frame_id & cfg.reply_flag_mask) != '0) begin
          if (cfg.text_func_id == base_id) begin
            slot_hit = 1'b1;
            slot_sel = 1'b0;
          end else if (cfg.ctrl_func_id == base_id) begin
            slot_hit = 1'b1;
            slot_sel = 1'b1;
          end
          if (slot_hit && ss_r[slot_sel] == ST_WAIT) begin
            if (item.byte0 == B_ACK) begin
              ss_nxt[slot_sel] = ST_DONE;
            end else if (item.byte0 == B_PART0 && item.byte1 == B_ONE &&
                         item.byte2 == B_ZERO) begin
              ss_nxt[slot_sel] = ST_PARTIAL;
            end else begin
              ss_nxt[slot_sel] = ST_ERROR;
            end
          end
        end else if (item.frame_id == cfg.keypress_id &&
                     item.byte0 == B_KEY_HDR && item.byte1 != B_KEY_PRESS) begin
          // malformed key frame: drop without acknowledge
        end else begin
          if (item.frame_id == cfg.keypress_id && wp_inc != rp_r) begin
            push   = 1'b1;
            wp_nxt = wp_inc;
          end
          f0_v    = 1'b1;
          f0_id   = item.frame_id | cfg.reply_flag_mask;
          f0_data = {B_ACK, fb, fb, fb, fb, fb, fb, fb};
        end
      end
      REQ_TICK: do_tick = 1'b1;
      REQ_POP: begin
        if (wp_r != rp_r) begin
          kv     = 1'b1;
          rp_nxt = rp_inc;
        end
      end
      REQ_ARM:     ss_nxt[item.slot] = ST_WAIT;
      REQ_RELEASE: ss_nxt[item.slot] = ST_IDLE;
      default: ;
    endcase

    if (do_tick) begin
      f0_v    = 1'b1;
      f0_id   = cfg.sync_tx_id;
      f0_data = {B_PING, B_ZERO, fb, fb, fb, fb, fb, fb};
      if ((lf_nxt & (LF_FAILED | LF_START)) != '0) begin
        f1_v    = 1'b1;
        f1_data = {B_SYNC_OUT, B_ONE, B_PAD_FIXED, B_PAD_FIXED,
                   B_PAD_FIXED, B_PAD_FIXED, B_PAD_FIXED, B_PAD_FIXED};
        lf_nxt  = lf_nxt & ~LF_START;
      end else if ((lf_nxt & LF_ALIVE) != '0) begin
        cd_nxt = cfg.ping_limit;
        lf_nxt = lf_nxt & ~LF_ALIVE;
      end else begin
        // count down, saturate at zero
        cd_dec = (cd_r != '0) ? cd_r - 1'b1 : '0;
        cd_nxt = cd_dec;
        if (cd_dec == '0) begin
          lf_nxt = LF_FAILED;
        end
      end
    end
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    res0.tx_valid         = f0_v;
    res0.tx_id            = f0_id;
    res0.tx_data          = f0_data;
    res0.last             = !f1_v;
    res0.key_valid        = kv;
    res0.key_code         = kv ? kc : '0;
    res0.link_status      = lf_nxt;
    res0.text_slot_status = ss_nxt[0];
    res0.ctrl_slot_status = ss_nxt[1];
    res1.tx_valid         = 1'b1;
    res1.tx_id            = cfg.sync_tx_id;
    res1.tx_data          = f1_data;
    res1.last             = 1'b1;
    res1.link_status      = lf_nxt;
    res1.text_slot_status = ss_nxt[0];
    res1.ctrl_slot_status = ss_nxt[1];
  end

  assign two_res = f1_v;

  // Read address runs one step ahead so the head key is ready at pop time
  assign raddr = fire ? rp_nxt : rp_r;

  dlk_ram #(
    .WIDTH(16),
    .DEPTH(KEY_QUEUE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (fire && push),
    .waddr(wp_r),
    .wdata({item.byte2, item.byte3}),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // Write into the entry being read: forward the new key
  always_ff @(posedge clk) begin
    byp_r      <= fire && push && (wp_r == raddr);
    byp_data_r <= {item.byte2, item.byte3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r  <= LF_FAILED;
      cd_r  <= PING_LIMIT_RST;
      ss_r[0] <= ST_IDLE;
      ss_r[1] <= ST_IDLE;
      wp_r  <= '0;
      rp_r  <= '0;
    end else if (fire) begin
      lf_r  <= lf_nxt;
      cd_r  <= cd_nxt;
      ss_r[0] <= ss_nxt[0];
      ss_r[1] <= ss_nxt[1];
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

endmodule

FILE: rtl/dlk_res_fifo.sv
// Four-entry result queue; takes one or two results per cycle, gives one.
// Uses dlk_pkg for the result record.
`timescale 1ns / 1ps

module dlk_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          push_two,
  input  dlk_pkg::res_t  din0,
  input  dlk_pkg::res_t  din1,
  output logic          room_two,
  output logic          head_valid,
  output dlk_pkg::res_t  head,
  input  logic          pop
);
  import dlk_pkg::*;

  res_t       ent_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rp_r];
  assign room_two   = (cnt_r <= 3'd2);
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r;
    rp_nxt  = rp_r;
    if (push) begin
      wp_nxt  = push_two ? wp_r + 2'd2 : wp_r + 2'd1;
      cnt_nxt = push_two ? cnt_r + 3'd2 : cnt_r + 3'd1;
    end
    if (do_pop) begin
      rp_nxt  = rp_r + 2'd1;
      cnt_nxt = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din0;
      if (push_two) begin
        ent_r[wp_r + 2'd1] <= din1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/display_link_keepalive_receiver_core.sv
// Top level of the display link keepalive receiver.
// Uses dlk_pkg, dlk_engine, dlk_ram and dlk_res_fifo.
//
//  Channel  Direction  Handshake             Carries
//  in_      slave      in_tvalid/in_tready   received frame, tick, pop, arm, release
//  out_     master     out_tvalid/out_tready one or two results per input transaction
//  cfg_     slave      cfg_valid/cfg_ready   register index and write data
//
// An input transaction is registered, then handled by the engine,
// which writes one or two results into a four-entry result queue.
// The engine takes an item whenever the queue has room for two results, so
// single-result items run one per cycle while out_tready is high, and
// two-result items are held back by the single output port of the queue.
// Reset is synchronous and clears control state; there is no clearing pass.
// cfg_ready is always high.
`timescale 1ns / 1ps

module display_link_keepalive_receiver_core #(
  parameter int KEY_QUEUE_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // frame_id, byte0, byte1, byte2, byte3, zero pad
  input  logic [3:0]   in_tuser,   // req_type, slot
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // tx_id, tx_data, key_code, link_status,
                                   // text_slot_status, ctrl_slot_status, zero pad
  output logic [1:0]   out_tuser,  // tx_valid, key_valid
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [10:0]  cfg_data
);
  import dlk_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  logic  item_vld_r;
  logic  fire, room_two, head_valid, two_res;
  res_t  res0, res1, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_tx_id      <= '0;
      cfg_r.sync_rx_id      <= '0;
      cfg_r.reply_flag_mask <= '0;
      cfg_r.keypress_id     <= '0;
      cfg_r.text_func_id    <= '0;
      cfg_r.ctrl_func_id    <= '0;
      cfg_r.ping_limit      <= PING_LIMIT_RST;
      cfg_r.filler_byte     <= FILLER_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_SYNC_TX_ID:   cfg_r.sync_tx_id      <= cfg_data;
        REG_SYNC_RX_ID:   cfg_r.sync_rx_id      <= cfg_data;
        REG_REPLY_MASK:   cfg_r.reply_flag_mask <= cfg_data;
        REG_KEYPRESS_ID:  cfg_r.keypress_id     <= cfg_data;
        REG_TEXT_FUNC_ID: cfg_r.text_func_id    <= cfg_data;
        REG_CTRL_FUNC_ID: cfg_r.ctrl_func_id    <= cfg_data;
        REG_PING_LIMIT:   cfg_r.ping_limit      <= cfg_data[6:0];
        REG_FILLER_BYTE:  cfg_r.filler_byte     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register: refill in the same cycle the held item is handled
  assign fire      = item_vld_r && room_two;
  assign in_tready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type <= in_tuser[2:0];
      item_r.slot     <= in_tuser[3];
      item_r.frame_id <= in_tdata[10:0];
      item_r.byte0    <= in_tdata[18:11];
      item_r.byte1    <= in_tdata[26:19];
      item_r.byte2    <= in_tdata[34:27];
      item_r.byte3    <= in_tdata[42:35];
    end
  end

  dlk_engine #(
    .KEY_QUEUE_DEPTH(KEY_QUEUE_DEPTH)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg_r),
    .res0   (res0),
    .res1   (res1),
    .two_res(two_res)
  );

  dlk_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_two  (two_res),
    .din0      (res0),
    .din1      (res1),
    .room_two  (room_two),
    .head_valid(head_valid),
    .head      (head),
    .pop       (out_tready)
  );

  assign out_tvalid = head_valid;
  assign out_tlast  = head.last;
  assign out_tuser  = {head.key_valid, head.tx_valid};
  assign out_tdata  = {4'b0000, head.ctrl_slot_status, head.text_slot_status,
                       head.link_status, head.key_code, head.tx_data, head.tx_id};

endmodule

FILE: rtl/dlk_checker.sv
// Port-level checks of the display link keepalive receiver, bound to its top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module dlk_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result without a frame is always the only one of its item
  a_noframe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("frameless result not last");

  // A popped key never shares a result with a frame
  a_key_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tlast)
    else $error("key result carries a frame");

  // Key code is zero unless a key was returned
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[90:75] == 16'd0)
    else $error("key code without key");

  // Two results of one item carry the same status
  a_status_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
    out_tvalid && out_tdata[99:91] == $past(out_tdata[99:91]))
    else $error("status differs within one item");

endmodule

bind display_link_keepalive_receiver_core dlk_checker u_dlk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
